@@ rtl/lcbb_pkg.sv @@
// shared types, constants and register codes for the lip color bounding box
package lcbb_pkg;

  // frame dimension limit, also the clamp for configured frame sizes
  localparam logic [12:0] MAX_DIM = 13'd4096;

  // lip pixel counter saturates here
  localparam logic [22:0] CNT_MAX = 23'h7FFFFF;

  // floor(n / 3) as (n * 21846) >> 16, exact for n below 32768
  localparam logic [14:0] DIV3_RECIP = 15'd21846;

  // cycles that the derived window needs after a register write
  localparam logic [1:0] CFG_SETTLE = 2'd3;

  // request queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // color conversion weights
  localparam logic [15:0]        Y_R  = 16'd77;
  localparam logic [15:0]        Y_G  = 16'd150;
  localparam logic [15:0]        Y_B  = 16'd29;
  localparam logic signed [17:0] CB_R = -18'sd43;
  localparam logic signed [17:0] CB_G = -18'sd85;
  localparam logic signed [17:0] CB_B = 18'sd128;
  localparam logic signed [17:0] CR_R = 18'sd128;
  localparam logic signed [17:0] CR_G = -18'sd107;
  localparam logic signed [17:0] CR_B = -18'sd21;
  localparam logic signed [17:0] CHROMA_OFS = 18'sd32768;

  // lip color ranges
  localparam logic [7:0] CR_LO = 8'd140;
  localparam logic [7:0] CR_HI = 8'd180;
  localparam logic [7:0] CB_LO = 8'd100;
  localparam logic [7:0] CB_HI = 8'd130;
  localparam logic [7:0] Y_LO  = 8'd50;
  localparam logic [7:0] Y_HI  = 8'd200;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_FACE_LEFT    = 3'd2,
    REG_FACE_TOP     = 3'd3,
    REG_FACE_SPAN_X  = 3'd4,
    REG_FACE_SPAN_Y  = 3'd5,
    REG_MIN_LIP      = 3'd6
  } cfg_reg_t;

  // derived mouth window and pass-through settings
  typedef struct packed {
    logic [12:0] w;
    logic [12:0] h;
    logic [12:0] mx;
    logic [12:0] mx_end;
    logic [12:0] my;
    logic [12:0] my_end;
    logic [12:0] face_span_y;
    logic [22:0] min_lip;
  } win_t;

  // classified pixel request in the queue
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] col;
    logic [11:0] row;
    logic        in_win;
    logic        last;
  } pix_t;

  // color-tested pixel
  typedef struct packed {
    logic        lip;
    logic        last;
    logic [11:0] col;
    logic [11:0] row;
  } stage1_t;

  // running bounding box
  typedef struct packed {
    logic [11:0] min_col;
    logic [11:0] max_col;
    logic [11:0] min_row;
    logic [11:0] max_row;
    logic [22:0] count;
  } acc_t;

  // frame totals waiting for result formatting
  typedef struct packed {
    logic [22:0] count;
    logic [12:0] c0;
    logic [12:0] c1;
    logic [12:0] r0;
    logic [12:0] r1;
  } fin_t;

endpackage

@@ rtl/lcbb_window.sv @@
// configuration registers and registered mouth window derivation
module lcbb_window (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [22:0]       cfg_data,
  output lcbb_pkg::win_t    win,
  output logic              settle_busy
);
  import lcbb_pkg::*;

  logic [12:0] frame_width_r;
  logic [12:0] frame_height_r;
  logic [11:0] face_left_r;
  logic [11:0] face_top_r;
  logic [12:0] face_span_x_r;
  logic [12:0] face_span_y_r;
  logic [22:0] min_lip_r;
  logic [1:0]  settle_r;

  // first stage
  logic [12:0] w_a_r, h_a_r, mx_a_r;
  logic [11:0] mw_a_r;
  logic [11:0] q2_a_r;
  logic [10:0] q1_a_r;
  logic [12:0] w_a_nxt, h_a_nxt, mx_a_nxt;
  logic [28:0] prod2;
  logic [27:0] prod1;

  // second stage
  logic [12:0] mx_end_nxt, my_nxt, my_end_nxt;
  logic [12:0] mx_sum, my_sum;
  logic [12:0] w_b_r, h_b_r, mx_b_r, mx_end_b_r, my_b_r, my_end_b_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 13'd640;
      frame_height_r <= 13'd480;
      face_left_r    <= '0;
      face_top_r     <= '0;
      face_span_x_r  <= '0;
      face_span_y_r  <= '0;
      min_lip_r      <= 23'd50;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[12:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[12:0];
        REG_FACE_LEFT:    face_left_r    <= cfg_data[11:0];
        REG_FACE_TOP:     face_top_r     <= cfg_data[11:0];
        REG_FACE_SPAN_X:  face_span_x_r  <= cfg_data[12:0];
        REG_FACE_SPAN_Y:  face_span_y_r  <= cfg_data[12:0];
        REG_MIN_LIP:      min_lip_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold off pixels until the window pipeline has caught up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= '0;
    end else if (cfg_we) begin
      settle_r <= CFG_SETTLE;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  assign settle_busy = (settle_r != 2'd0);

  // clamp frame size, quarter and half of the face width, thirds of the height
  always_comb begin
    w_a_nxt  = (frame_width_r > MAX_DIM) ? MAX_DIM : frame_width_r;
    h_a_nxt  = (frame_height_r > MAX_DIM) ? MAX_DIM : frame_height_r;
    mx_a_nxt = {1'b0, face_left_r} + {2'b00, face_span_x_r[12:2]};
  end

  assign prod2 = 29'({face_span_y_r, 1'b0}) * 29'(DIV3_RECIP);
  assign prod1 = 28'(face_span_y_r) * 28'(DIV3_RECIP);

  always_ff @(posedge clk) begin
    w_a_r  <= w_a_nxt;
    h_a_r  <= h_a_nxt;
    mx_a_r <= mx_a_nxt;
    mw_a_r <= face_span_x_r[12:1];
    q2_a_r <= prod2[27:16];
    q1_a_r <= prod1[26:16];
  end

  // window edges clamped to the frame, empty when the start is outside
  always_comb begin
    mx_sum = mx_a_r + {1'b0, mw_a_r};
    if (mx_a_r >= w_a_r) begin
      mx_end_nxt = mx_a_r;
    end else if (mx_sum > w_a_r) begin
      mx_end_nxt = w_a_r;
    end else begin
      mx_end_nxt = mx_sum;
    end
    my_nxt = {1'b0, face_top_r} + {1'b0, q2_a_r};
    my_sum = my_nxt + {2'b00, q1_a_r};
    if (my_nxt >= h_a_r) begin
      my_end_nxt = my_nxt;
    end else if (my_sum > h_a_r) begin
      my_end_nxt = h_a_r;
    end else begin
      my_end_nxt = my_sum;
    end
  end

  always_ff @(posedge clk) begin
    w_b_r      <= w_a_r;
    h_b_r      <= h_a_r;
    mx_b_r     <= mx_a_r;
    mx_end_b_r <= mx_end_nxt;
    my_b_r     <= my_nxt;
    my_end_b_r <= my_end_nxt;
  end

  always_comb begin
    win.w           = w_b_r;
    win.h           = h_b_r;
    win.mx          = mx_b_r;
    win.mx_end      = mx_end_b_r;
    win.my          = my_b_r;
    win.my_end      = my_end_b_r;
    win.face_span_y = face_span_y_r;
    win.min_lip     = min_lip_r;
  end

endmodule

@@ rtl/lcbb_front.sv @@
// front end: accepts pixels, tracks raster position, tags window membership
module lcbb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  input  logic              in_frame_end,
  input  lcbb_pkg::win_t    win,
  input  logic              settle_busy,
  input  logic              fifo_full,
  output logic              push,
  output lcbb_pkg::pix_t    push_data
);
  import lcbb_pkg::*;

  logic [11:0] col_r, col_nxt;
  logic [11:0] row_r, row_nxt;
  logic [12:0] col_inc, row_inc;
  logic        in_win;

  assign in_ready = !settle_busy && !fifo_full;
  assign push     = in_valid && in_ready;

  // raster position advance with wrap at frame edges
  always_comb begin
    col_inc = {1'b0, col_r} + 13'd1;
    row_inc = {1'b0, row_r} + 13'd1;
    col_nxt = col_r;
    row_nxt = row_r;
    if (push) begin
      if (in_frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= win.w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= win.h) ? 12'd0 : row_inc[11:0];
      end else begin
        col_nxt = col_inc[11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // mouth window membership
  assign in_win = ({1'b0, col_r} >= win.mx) && ({1'b0, col_r} < win.mx_end) &&
                  ({1'b0, row_r} >= win.my) && ({1'b0, row_r} < win.my_end);

  always_comb begin
    push_data.red    = in_red;
    push_data.green  = in_green;
    push_data.blue   = in_blue;
    push_data.col    = col_r;
    push_data.row    = row_r;
    push_data.in_win = in_win;
    push_data.last   = in_frame_end;
  end

endmodule

@@ rtl/lcbb_fifo.sv @@
// short request queue between front and back
module lcbb_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lcbb_pkg::pix_t    push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output lcbb_pkg::pix_t    pop_data
);
  import lcbb_pkg::*;

  pix_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign full      = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/lcbb_back.sv @@
// back end: color test, bounding box accumulation and result register
module lcbb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fifo_valid,
  input  lcbb_pkg::pix_t    fifo_data,
  output logic              pop,
  input  lcbb_pkg::win_t    win,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_lips_found,
  output logic [11:0]       out_center_col,
  output logic [11:0]       out_center_row,
  output logic [12:0]       out_box_width,
  output logic [12:0]       out_box_height,
  output logic [22:0]       out_lip_area,
  output logic [12:0]       out_face_height_echo
);
  import lcbb_pkg::*;

  logic              en;
  logic [17:0]       rs, gs, bs;
  logic [15:0]       y_sum;
  logic signed [17:0] cb_sum, cr_sum, cb_off, cr_off;
  logic [7:0]        y8, cb8, cr8;
  logic              color_hit;

  logic              s1_valid_r;
  stage1_t           s1_r, s1_nxt;
  acc_t              acc_r, acc_upd, acc_nxt;
  logic              fin_valid_r;
  fin_t              fin_r, fin_nxt;

  logic              found;
  logic [13:0]       csum, rsum;
  logic              out_valid_r;
  logic              lips_found_r;
  logic [11:0]       center_col_r, center_row_r;
  logic [12:0]       box_width_r, box_height_r;
  logic [22:0]       lip_area_r;
  logic [12:0]       face_height_r;

  // whole back pipeline moves unless a result is stuck at the output
  assign en  = !out_valid_r || out_ready;
  assign pop = en && fifo_valid;

  // ycbcr conversion with constant weights
  always_comb begin
    rs     = {10'd0, fifo_data.red};
    gs     = {10'd0, fifo_data.green};
    bs     = {10'd0, fifo_data.blue};
    y_sum  = Y_R * {8'd0, fifo_data.red} + Y_G * {8'd0, fifo_data.green} +
             Y_B * {8'd0, fifo_data.blue};
    cb_sum = CB_R * $signed(rs) + CB_G * $signed(gs) + CB_B * $signed(bs);
    cr_sum = CR_R * $signed(rs) + CR_G * $signed(gs) + CR_B * $signed(bs);
    cb_off = cb_sum + CHROMA_OFS;
    cr_off = cr_sum + CHROMA_OFS;
    y8     = y_sum[15:8];
    cb8    = cb_off[15:8];
    cr8    = cr_off[15:8];
    color_hit = (cr8 >= CR_LO) && (cr8 <= CR_HI) &&
                (cb8 >= CB_LO) && (cb8 <= CB_HI) &&
                (y8 >= Y_LO) && (y8 <= Y_HI) && (cr8 > cb8);
    s1_nxt.lip  = color_hit && fifo_data.in_win;
    s1_nxt.last = fifo_data.last;
    s1_nxt.col  = fifo_data.col;
    s1_nxt.row  = fifo_data.row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= fifo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  // bounding box update for a lip pixel
  always_comb begin
    acc_upd = acc_r;
    if (s1_r.lip) begin
      if (acc_r.count == '0) begin
        acc_upd.min_col = s1_r.col;
        acc_upd.max_col = s1_r.col;
        acc_upd.min_row = s1_r.row;
        acc_upd.max_row = s1_r.row;
      end else begin
        if (s1_r.col < acc_r.min_col) acc_upd.min_col = s1_r.col;
        if (s1_r.col > acc_r.max_col) acc_upd.max_col = s1_r.col;
        if (s1_r.row < acc_r.min_row) acc_upd.min_row = s1_r.row;
        if (s1_r.row > acc_r.max_row) acc_upd.max_row = s1_r.row;
      end
      if (acc_r.count != CNT_MAX) begin
        acc_upd.count = acc_r.count + 23'd1;
      end
    end
  end

  // clear at frame end, otherwise keep the update
  always_comb begin
    acc_nxt = acc_r;
    if (en && s1_valid_r) begin
      acc_nxt = s1_r.last ? '0 : acc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // frame totals, empty box falls back to window edges
  always_comb begin
    fin_nxt.count = acc_upd.count;
    if (acc_upd.count == '0) begin
      fin_nxt.c0 = win.mx_end;
      fin_nxt.c1 = win.mx;
      fin_nxt.r0 = win.my_end;
      fin_nxt.r1 = win.my;
    end else begin
      fin_nxt.c0 = {1'b0, acc_upd.min_col};
      fin_nxt.c1 = {1'b0, acc_upd.max_col};
      fin_nxt.r0 = {1'b0, acc_upd.min_row};
      fin_nxt.r1 = {1'b0, acc_upd.max_row};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (en) begin
      fin_valid_r <= s1_valid_r && s1_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid_r && s1_r.last) begin
      fin_r <= fin_nxt;
    end
  end

  // result formatting
  always_comb begin
    found = (fin_r.count >= win.min_lip);
    csum  = {1'b0, fin_r.c0} + {1'b0, fin_r.c1};
    rsum  = {1'b0, fin_r.r0} + {1'b0, fin_r.r1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && fin_valid_r) begin
      lips_found_r  <= found;
      center_col_r  <= found ? csum[12:1] : 12'd0;
      center_row_r  <= found ? rsum[12:1] : 12'd0;
      box_width_r   <= found ? (fin_r.c1 - fin_r.c0 + 13'd1) : 13'd0;
      box_height_r  <= found ? (fin_r.r1 - fin_r.r0 + 13'd1) : 13'd0;
      lip_area_r    <= found ? fin_r.count : 23'd0;
      face_height_r <= win.face_span_y;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_lips_found       = lips_found_r;
  assign out_center_col       = center_col_r;
  assign out_center_row       = center_row_r;
  assign out_box_width        = box_width_r;
  assign out_box_height       = box_height_r;
  assign out_lip_area         = lip_area_r;
  assign out_face_height_echo = face_height_r;

endmodule

@@ rtl/lip_color_bounding_box_core.sv @@
// top level of the lip color bounding box detector
//
//   channel  direction  handshake          payload
//   in_      request    in_valid/in_ready  red, green, blue, frame_end
//   out_     result     out_valid/out_ready lips_found .. face_height_echo
//   cfg_     write      cfg_we             cfg_index, cfg_data
//
// one pixel per clock while in_ready is high; a pixel's result is registered in
// turn by the queue, color stage, accumulate stage and output register
// a register write blocks pixels while the window settles
// reset is synchronous and clears position, accumulators, queue and valids
// a stalled output stops the back end; the four-entry queue then fills and
// drops in_ready
module lip_color_bounding_box_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_lips_found,
  output logic [11:0] out_center_col,
  output logic [11:0] out_center_row,
  output logic [12:0] out_box_width,
  output logic [12:0] out_box_height,
  output logic [22:0] out_lip_area,
  output logic [12:0] out_face_height_echo,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_data
);
  import lcbb_pkg::*;

  win_t win;
  logic settle_busy;
  logic fifo_full, fifo_valid, push, pop;
  pix_t push_data, pop_data;

  // configuration and window
  lcbb_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .win         (win),
    .settle_busy (settle_busy)
  );

  // pixel intake
  lcbb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_frame_end (in_frame_end),
    .win          (win),
    .settle_busy  (settle_busy),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_data    (push_data)
  );

  // decoupling queue
  lcbb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .not_empty (fifo_valid),
    .pop_data  (pop_data)
  );

  // color test, accumulation, result
  lcbb_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .fifo_valid           (fifo_valid),
    .fifo_data            (pop_data),
    .pop                  (pop),
    .win                  (win),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_lips_found       (out_lips_found),
    .out_center_col       (out_center_col),
    .out_center_row       (out_center_row),
    .out_box_width        (out_box_width),
    .out_box_height       (out_box_height),
    .out_lip_area         (out_lip_area),
    .out_face_height_echo (out_face_height_echo)
  );

endmodule

@@ rtl/lcbb_checker.sv @@
// port-level checks for the lip color bounding box core, with bind
module lcbb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_red,
  input logic [7:0]  in_green,
  input logic [7:0]  in_blue,
  input logic        in_frame_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_lips_found,
  input logic [11:0] out_center_col,
  input logic [11:0] out_center_row,
  input logic [12:0] out_box_width,
  input logic [12:0] out_box_height,
  input logic [22:0] out_lip_area,
  input logic [12:0] out_face_height_echo,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [22:0] cfg_data
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lip_area) &&
    $stable(out_center_col) && $stable(out_lips_found))
    else $error("result changed while stalled");

  // a miss carries zero geometry
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_lips_found |-> out_center_col == 12'd0 &&
    out_center_row == 12'd0 && out_box_width == 13'd0 &&
    out_box_height == 13'd0 && out_lip_area == 23'd0)
    else $error("invalid detection with nonzero geometry");

  // a box built from lip pixels is never empty
  a_box_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lips_found && out_lip_area != 23'd0 |->
    out_box_width != 13'd0 && out_box_height != 13'd0)
    else $error("empty box with lip pixels");

  // pixels are held off right after a register write
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("pixel taken while window settles");

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lip_color_bounding_box_core lcbb_checker u_lcbb_checker (.*);
